// ===== hw/rtl/sctld_pkg.sv =====
// Package for the serial command and time line decoder.
// Holds the byte codes, result codes, line buffer sizing and the result beat type.
// No dependencies.
package sctld_pkg;

  // Line buffer sizing: one slot of the receive buffer is kept for the terminator.
  localparam int unsigned BufferBytes = 16;
  localparam int unsigned LineCap     = BufferBytes - 1;
  localparam int unsigned LenW        = $clog2(LineCap + 1);
  localparam int unsigned IdxW        = $clog2(LineCap);

  // Command bytes
  localparam logic [7:0] BYTE_LED_ON      = 8'h01;
  localparam logic [7:0] BYTE_LED_OFF     = 8'h02;
  localparam logic [7:0] BYTE_LDR_JUMP    = 8'h03;
  localparam logic [7:0] BYTE_LDR_UPDATE  = 8'h04;
  localparam logic [7:0] BYTE_RUNTIME     = 8'h05;
  localparam logic [7:0] BYTE_RESET       = 8'h06;
  localparam logic [7:0] BYTE_PWM         = 8'h07;
  localparam logic [7:0] BYTE_SLEEP       = 8'h08;
  localparam logic [7:0] BYTE_STOP        = 8'h09;
  localparam logic [7:0] BYTE_STANDBY     = 8'h0A;
  localparam logic [7:0] BYTE_CR          = 8'h0D;
  localparam logic [7:0] BYTE_PRINTABLE   = 8'h20;
  localparam logic [7:0] BYTE_VERSION     = 8'hA1;
  localparam logic [7:0] BYTE_UP          = 8'h77; // 'w'
  localparam logic [7:0] BYTE_DOWN        = 8'h73; // 's'
  localparam logic [7:0] BYTE_RIGHT       = 8'h64; // 'd'
  localparam logic [7:0] BYTE_LEFT        = 8'h61; // 'a'
  localparam logic [7:0] BYTE_GAME_RESET  = 8'h72; // 'r'
  localparam logic [7:0] BYTE_OPT_I       = 8'h69; // 'i'
  localparam logic [7:0] BYTE_OPT_J       = 8'h6A; // 'j'

  // Time line header and field positions
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_I     = 8'h49;
  localparam logic [7:0] CHR_M     = 8'h4D;
  localparam logic [7:0] CHR_E     = 8'h45;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam int unsigned TimeMinLen = 13;
  localparam int unsigned PosHour    = 5;
  localparam int unsigned PosMin     = 8;
  localparam int unsigned PosSec     = 11;
  localparam logic [7:0] HOUR_LIMIT  = 8'd24;
  localparam logic [7:0] MIN_LIMIT   = 8'd60;

  // Action codes
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_PWM        = 4'd7;
  localparam logic [3:0] ACT_VERSION    = 4'd8;
  localparam logic [3:0] ACT_VERSION_WL = 4'd9;

  // Shutdown codes
  localparam logic [1:0] SHD_NONE    = 2'd0;
  localparam logic [1:0] SHD_SLEEP   = 2'd1;
  localparam logic [1:0] SHD_STOP    = 2'd2;
  localparam logic [1:0] SHD_STANDBY = 2'd3;

  // Move codes
  localparam logic [2:0] MOV_NONE  = 3'd0;
  localparam logic [2:0] MOV_UP    = 3'd1;
  localparam logic [2:0] MOV_DOWN  = 3'd2;
  localparam logic [2:0] MOV_RIGHT = 3'd3;
  localparam logic [2:0] MOV_LEFT  = 3'd4;
  localparam logic [2:0] MOV_GAME  = 3'd5;

  // Option codes
  localparam logic [1:0] OPT_NONE = 2'd0;
  localparam logic [1:0] OPT_GAME = 2'd1;
  localparam logic [1:0] OPT_I    = 2'd2;
  localparam logic [1:0] OPT_J    = 2'd3;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] pwm_duty;
    logic [1:0] shutdown_mode;
    logic [2:0] move_code;
    logic [1:0] option_code;
    logic       time_written;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic       time_valid;
  } result_t;

  // Two ASCII digits to a value, wrapping at 8 bits.
  function automatic logic [7:0] two_digits(logic [7:0] hi, logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CHR_ZERO;
    l = lo - CHR_ZERO;
    return (h << 3) + (h << 1) + l;
  endfunction

endpackage

// ===== hw/rtl/serial_command_and_time_line_decoder.sv =====
// Top level of the serial command and time line decoder.
// Decodes one received byte per beat into one result beat; uses sctld_pkg.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o      | mode_i, byte_value_i
//   out     | output    | out_valid_o / out_stall_i    | action_o .. time_valid_o
//   cfg     | input     | cfg_we_i (no wait)           | cfg_wdata_i (wireless_armed)
//
// Each byte beat is decoded in the cycle it is accepted; the result goes to the output
// register, or to the skid slot when the sink stalls; one beat per cycle without stalls.
// Reset clears the armed flag, the pending duty flag, the line length and the valid flags
// of both output slots; the line bytes and the slot payloads are not cleared.
// A skid slot behind the output register absorbs one beat when the sink stalls, so
// in_stall_o is a registered flag that rises only once both slots are full.
module serial_command_and_time_line_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] action_o,
  output logic [7:0] pwm_duty_o,
  output logic [1:0] shutdown_mode_o,
  output logic [2:0] move_code_o,
  output logic [1:0] option_code_o,
  output logic       time_written_o,
  output logic [7:0] hours_o,
  output logic [7:0] minutes_o,
  output logic [7:0] seconds_o,
  output logic       time_valid_o
);
  import sctld_pkg::*;

  // Control state
  logic            armed_q;
  logic            duty_q, duty_d;
  logic [LenW-1:0] len_q, len_d;
  logic            out_vld_q, out_vld_d;
  logic            skid_vld_q, skid_vld_d;

  // Payload state
  logic [7:0] line_q [LineCap];
  result_t    out_q, skid_q;
  result_t    res;

  logic accept;
  logic out_fire;
  logic wireless;
  logic store_we;
  logic parse_ok;
  logic [7:0] hrs, mins, secs;

  assign accept   = in_valid_i & ~skid_vld_q;
  assign out_fire = out_vld_q & ~out_stall_i;
  assign wireless = mode_i;

  // Time fields come straight off fixed line positions; header and length gate them.
  assign hrs  = two_digits(line_q[PosHour], line_q[PosHour + 1]);
  assign mins = two_digits(line_q[PosMin],  line_q[PosMin + 1]);
  assign secs = two_digits(line_q[PosSec],  line_q[PosSec + 1]);
  assign parse_ok = (len_q >= LenW'(TimeMinLen)) &&
                    (line_q[0] == CHR_T) && (line_q[1] == CHR_I) &&
                    (line_q[2] == CHR_M) && (line_q[3] == CHR_E) &&
                    (line_q[4] == CHR_COLON);

  // Decode the incoming byte against the current state.
  always_comb begin
    res      = '0;
    duty_d   = duty_q;
    len_d    = len_q;
    store_we = 1'b0;
    if (wireless && !armed_q) begin
      // Unarmed wireless byte: drop it, leave all state alone.
      res = '0;
    end else if (duty_q) begin
      // Second byte of the PWM command: take it as the duty value.
      duty_d       = 1'b0;
      res.action   = ACT_PWM;
      res.pwm_duty = byte_value_i;
    end else begin
      unique case (byte_value_i) inside
        BYTE_LED_ON, BYTE_LED_OFF, BYTE_LDR_JUMP, BYTE_LDR_UPDATE,
        BYTE_RUNTIME, BYTE_RESET: begin
          res.action = byte_value_i[3:0];
        end
        BYTE_PWM:        duty_d = 1'b1;
        BYTE_SLEEP:      res.shutdown_mode = SHD_SLEEP;
        BYTE_STOP:       res.shutdown_mode = SHD_STOP;
        BYTE_STANDBY:    res.shutdown_mode = SHD_STANDBY;
        BYTE_VERSION:    res.action = wireless ? ACT_VERSION_WL : ACT_VERSION;
        BYTE_UP:         res.move_code = MOV_UP;
        BYTE_DOWN:       res.move_code = MOV_DOWN;
        BYTE_RIGHT:      res.move_code = MOV_RIGHT;
        BYTE_LEFT:       res.move_code = MOV_LEFT;
        BYTE_GAME_RESET: begin
          res.move_code   = MOV_GAME;
          res.option_code = OPT_GAME;
        end
        BYTE_OPT_I:      res.option_code = OPT_I;
        BYTE_OPT_J:      res.option_code = OPT_J;
        default: begin
          if (wireless) begin
            if (byte_value_i == BYTE_CR) begin
              // End of line: parse if it is a time line, then start over.
              if (parse_ok) begin
                res.time_written = 1'b1;
                res.hours        = hrs;
                res.minutes      = mins;
                res.seconds      = secs;
                res.time_valid   = (hrs < HOUR_LIMIT) && (mins < MIN_LIMIT) &&
                                   (secs < MIN_LIMIT);
              end
              len_d = '0;
            end else if (byte_value_i >= BYTE_PRINTABLE && len_q < LenW'(LineCap)) begin
              // Printable byte with room left: append it.
              store_we = 1'b1;
              len_d    = len_q + LenW'(1);
            end
          end
        end
      endcase
    end
  end

  // Output register with one skid slot behind it.
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_fire) begin
      out_vld_d  = skid_vld_q | accept;
      skid_vld_d = 1'b0;
    end else if (accept) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      duty_q     <= 1'b0;
      len_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        armed_q <= cfg_wdata_i;
      end
      if (accept) begin
        duty_q <= duty_d;
        len_q  <= len_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload: advance the output slot from skid or the fresh result, park in skid on stall.
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_fire) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  // Line bytes: written once per appended byte, never cleared.
  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      line_q[len_q[IdxW-1:0]] <= byte_value_i;
    end
  end

  assign in_stall_o      = skid_vld_q;
  assign out_valid_o     = out_vld_q;
  assign action_o        = out_q.action;
  assign pwm_duty_o      = out_q.pwm_duty;
  assign shutdown_mode_o = out_q.shutdown_mode;
  assign move_code_o     = out_q.move_code;
  assign option_code_o   = out_q.option_code;
  assign time_written_o  = out_q.time_written;
  assign hours_o         = out_q.hours;
  assign minutes_o       = out_q.minutes;
  assign seconds_o       = out_q.seconds;
  assign time_valid_o    = out_q.time_valid;

endmodule
